[design/svsdl_pkg.sv]
// Shared types, constants and phase codes of the spray valve sequencer.
`default_nettype none
package svsdl_pkg;

  localparam int unsigned WINDOW_DEFAULT = 4096;

  localparam int unsigned TIME_W   = 20;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned TOTAL_W  = 40;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned OUTCNT_W = 12;
  localparam int unsigned IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_SPRAY_TIME  = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_DELAY = 3'd1;
  localparam logic [IDX_W-1:0] REG_REARM_TIME  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_DUTY    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SAMPLE_PER  = 3'd4;

  localparam logic [TIME_W-1:0]   SPRAY_TIME_RST  = 20'd1000;
  localparam logic [TIME_W-1:0]   START_DELAY_RST = 20'd0;
  localparam logic [TIME_W-1:0]   REARM_TIME_RST  = 20'd0;
  localparam logic [PCT_W-1:0]    MAX_DUTY_RST    = 7'd100;
  localparam logic [PERIOD_W-1:0] SAMPLE_PER_RST  = 16'd1;

  localparam logic [PCT_W-1:0]    PCT_FULL = 7'd100;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DELAY = 2'd1;
  localparam logic [1:0] PH_SPRAY = 2'd2;
  localparam logic [1:0] PH_HOLD  = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] spray_ms;
    logic [TIME_W-1:0] delay_ms;
    logic [TIME_W-1:0] rearm_ms;
  } seq_cfg_t;

  typedef struct packed {
    logic tick;
    logic valve;
  } win_ctrl_t;

  typedef struct packed {
    logic over;
    logic under;
  } duty_t;

endpackage
`default_nettype wire

[design/svsdl_window.sv]
// Duty window ring memory with sample divider, on-sample count and limit compare.
`default_nettype none
module svsdl_window
  import svsdl_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire win_ctrl_t           ctrl,
  input  wire logic [PERIOD_W-1:0] period_cfg,
  input  wire logic [PCT_W-1:0]    pct,
  output duty_t                    duty,
  output logic [OUTCNT_W-1:0]      count_out
);

  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned DUTY_W = CNT_W + PCT_W;
  localparam int unsigned SAT_W  = (CNT_W > OUTCNT_W) ? CNT_W : OUTCNT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic              mem [WINDOW];
  logic              rd_bit;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  next1;
  logic [PTR_W-1:0]  next2;
  logic [PTR_W-1:0]  rd_addr;
  logic              wrapped;
  logic [CNT_W-1:0]  on_count;
  logic [CNT_W-1:0]  on_count_next;
  logic [CNT_W-1:0]  cnt_add;
  logic [PERIOD_W-1:0] divider;
  logic [PERIOD_W:0] div_inc;
  logic [PERIOD_W:0] period;
  logic              sample;
  logic              old_bit;
  logic [DUTY_W-1:0] duty_val;
  logic [DUTY_W-1:0] limit;
  logic [SAT_W-1:0]  cnt_wide;

  assign next1   = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
  assign next2   = (next1 == PTR_LAST) ? '0 : next1 + PTR_W'(1);
  assign period  = (period_cfg == '0) ? (PERIOD_W + 1)'(1) : {1'b0, period_cfg};
  assign div_inc = {1'b0, divider} + (PERIOD_W + 1)'(1);
  assign sample  = ctrl.tick && (div_inc >= period);
  assign rd_addr = sample ? next2 : next1;
  assign old_bit = rd_bit && (wrapped || (next1 == '0));
  assign cnt_add = on_count + CNT_W'(ctrl.valve);

  always_comb begin
    on_count_next = on_count;
    if (sample) begin
      on_count_next = (old_bit && (cnt_add != '0)) ? cnt_add - CNT_W'(1) : cnt_add;
    end
  end

  assign duty_val   = DUTY_W'(on_count_next) * DUTY_W'(PCT_FULL);
  assign limit      = DUTY_W'(pct) * DUTY_W'(WINDOW);
  assign duty.over  = duty_val > limit;
  assign duty.under = duty_val < limit;

  assign cnt_wide  = SAT_W'(on_count);
  assign count_out = (cnt_wide > SAT_W'({OUTCNT_W{1'b1}})) ? {OUTCNT_W{1'b1}}
                                                           : cnt_wide[OUTCNT_W-1:0];

  always_ff @(posedge clk) begin
    if (sample) begin
      mem[ptr] <= ctrl.valve;
    end
    rd_bit <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      wrapped  <= 1'b0;
      on_count <= '0;
      divider  <= '0;
    end else if (ctrl.tick) begin
      on_count <= on_count_next;
      if (sample) begin
        divider <= '0;
        ptr     <= next1;
        if (ptr == PTR_LAST) begin
          wrapped <= 1'b1;
        end
      end else begin
        divider <= div_inc[PERIOD_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

[design/svsdl_seq.sv]
// Phase sequencer with phase timer and saturating spray totals.
`default_nettype none
module svsdl_seq
  import svsdl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               tick,
  input  wire logic               presence,
  input  wire logic               clear_counters,
  input  wire seq_cfg_t           cfg,
  input  wire duty_t              duty,
  output logic                    valve,
  output logic [1:0]              phase,
  output logic [TIME_W-1:0]       elapsed,
  output logic [TOTAL_W-1:0]      total,
  output logic [COUNT_W-1:0]      passes,
  output logic [COUNT_W-1:0]      opens
);

  logic               valve_next;
  logic [1:0]         phase_next;
  logic [TIME_W-1:0]  elapsed_next;
  logic [TOTAL_W-1:0] total_next;
  logic [COUNT_W-1:0] passes_next;
  logic [COUNT_W-1:0] opens_next;

  logic [TIME_W-1:0]  el_inc;
  logic [TOTAL_W-1:0] tot_base;
  logic [COUNT_W-1:0] pass_base;
  logic [COUNT_W-1:0] open_base;
  logic [TOTAL_W:0]   tot_sum;
  logic [TOTAL_W-1:0] tot_end;
  logic [COUNT_W-1:0] pass_inc;
  logic [COUNT_W-1:0] open_inc;
  logic               keep_on;

  assign el_inc    = (elapsed == '1) ? elapsed : elapsed + TIME_W'(1);
  assign tot_base  = clear_counters ? '0 : total;
  assign pass_base = clear_counters ? '0 : passes;
  assign open_base = clear_counters ? '0 : opens;
  assign tot_sum   = {1'b0, tot_base} + (TOTAL_W + 1)'(el_inc);
  assign tot_end   = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
  assign pass_inc  = (pass_base == '1) ? pass_base : pass_base + COUNT_W'(1);
  assign open_inc  = (open_base == '1) ? open_base : open_base + COUNT_W'(1);
  assign keep_on   = (cfg.delay_ms == '0) && (cfg.rearm_ms == '0) && presence;

  always_comb begin
    phase_next   = phase;
    valve_next   = valve;
    elapsed_next = el_inc;
    total_next   = tot_base;
    passes_next  = pass_base;
    opens_next   = open_base;
    unique case (phase)
      PH_IDLE: begin
        if (presence && (el_inc > cfg.rearm_ms)) begin
          phase_next   = PH_DELAY;
          elapsed_next = '0;
        end
      end
      PH_DELAY: begin
        if (el_inc > cfg.delay_ms) begin
          phase_next   = PH_SPRAY;
          valve_next   = 1'b1;
          opens_next   = open_inc;
          elapsed_next = '0;
        end
      end
      PH_SPRAY: begin
        if (duty.over) begin
          total_next   = tot_end;
          passes_next  = pass_inc;
          phase_next   = PH_HOLD;
          valve_next   = 1'b0;
          elapsed_next = '0;
        end else if (el_inc > cfg.spray_ms) begin
          total_next   = tot_end;
          passes_next  = pass_inc;
          elapsed_next = '0;
          if (!keep_on) begin
            phase_next = PH_IDLE;
            valve_next = 1'b0;
          end
        end
      end
      default: begin
        if (duty.under) begin
          phase_next   = PH_IDLE;
          elapsed_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      valve   <= 1'b0;
      elapsed <= '0;
      total   <= '0;
      passes  <= '0;
      opens   <= '0;
    end else if (tick) begin
      phase   <= phase_next;
      valve   <= valve_next;
      elapsed <= elapsed_next;
      total   <= total_next;
      passes  <= passes_next;
      opens   <= opens_next;
    end
  end

endmodule
`default_nettype wire

[design/spray_valve_sequencer_duty_limit.sv]
// Spray valve sequencer with sliding-window duty limit: top level.
//
// Each input transaction is one millisecond tick carrying presence and
// clear_counters. Every accepted tick yields exactly one output transaction
// with the valve drive, phase, window on-count, phase timer and the spray,
// pass and opening totals as they stand after that tick.
// The result of a tick is registered and valid in the cycle after it is
// accepted. One tick per cycle is taken while no held result stalls input; the
// ring memory is read one slot ahead of the write pointer: reads never stall.
// The state registers double as the output register: while the receiver holds
// out_stall with a result pending, in_stall is raised and nothing advances.
// Configuration writes go through cfg_valid/cfg_ready (always ready); the user
// must make them only while no tick is in flight (the block does not check).
// Reset clears phase, timers, totals, window pointer and count, and loads the
// register defaults. The ring needs no clearing pass: a wrap flag marks slots
// not yet written as off, so the block takes ticks from the first cycle.
`default_nettype none
module spray_valve_sequencer_duty_limit
  import svsdl_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [IDX_W-1:0]     cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 presence,
  input  wire logic                 clear_counters,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      valve_on,
  output logic [1:0]                phase,
  output logic [OUTCNT_W-1:0]       window_on_count,
  output logic [TIME_W-1:0]         phase_elapsed_ms,
  output logic [TOTAL_W-1:0]        total_spray_ms,
  output logic [COUNT_W-1:0]        pass_total,
  output logic [COUNT_W-1:0]        opening_total
);

  logic [TIME_W-1:0]   spray_time_ms;
  logic [TIME_W-1:0]   start_delay_ms;
  logic [TIME_W-1:0]   rearm_time_ms;
  logic [PCT_W-1:0]    max_duty_percent;
  logic [PERIOD_W-1:0] sample_period_ticks;

  logic       accept;
  logic       cfg_write;
  logic [PCT_W-1:0] pct;
  seq_cfg_t   seq_cfg;
  win_ctrl_t  win_ctrl;
  duty_t      duty;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign pct              = (max_duty_percent > PCT_FULL) ? PCT_FULL : max_duty_percent;
  assign seq_cfg.spray_ms = spray_time_ms;
  assign seq_cfg.delay_ms = start_delay_ms;
  assign seq_cfg.rearm_ms = rearm_time_ms;
  assign win_ctrl.tick    = accept;
  assign win_ctrl.valve   = valve_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      spray_time_ms       <= SPRAY_TIME_RST;
      start_delay_ms      <= START_DELAY_RST;
      rearm_time_ms       <= REARM_TIME_RST;
      max_duty_percent    <= MAX_DUTY_RST;
      sample_period_ticks <= SAMPLE_PER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPRAY_TIME:  spray_time_ms       <= cfg_data;
        REG_START_DELAY: start_delay_ms      <= cfg_data;
        REG_REARM_TIME:  rearm_time_ms       <= cfg_data;
        REG_MAX_DUTY:    max_duty_percent    <= cfg_data[PCT_W-1:0];
        REG_SAMPLE_PER:  sample_period_ticks <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || in_stall;
    end
  end

  svsdl_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (win_ctrl),
    .period_cfg(sample_period_ticks),
    .pct       (pct),
    .duty      (duty),
    .count_out (window_on_count)
  );

  svsdl_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .tick          (accept),
    .presence      (presence),
    .clear_counters(clear_counters),
    .cfg           (seq_cfg),
    .duty          (duty),
    .valve         (valve_on),
    .phase         (phase),
    .elapsed       (phase_elapsed_ms),
    .total         (total_spray_ms),
    .passes        (pass_total),
    .opens         (opening_total)
  );

endmodule
`default_nettype wire
